[rtl/pel_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pel_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package pel_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int IPOS_W   = 5;
  localparam int OPOS_W   = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_DUMP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_ALLOC,
    S_LINK1,
    S_LINK2,
    S_WALK,
    S_FOUND,
    S_INS1,
    S_INS2,
    S_REM,
    S_DRD,
    S_DLD,
    S_DOUT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic pop;
    logic push;
  } free_ctl_t;

endpackage
`default_nettype wire

[rtl/pel_item_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pel_item_if
// Request channel: valid/ready handshake with one request per transaction.
// ----------------------------------------------------------------------------
interface pel_item_if;
  logic                                valid;
  logic                                ready;
  pel_pkg::func_t                      func;
  logic signed [pel_pkg::VALUE_W-1:0]  item_value;
  logic        [pel_pkg::IPOS_W-1:0]   item_position;

  modport source (output valid, func, item_value, item_position, input ready);
  modport sink   (input valid, func, item_value, item_position, output ready);
endinterface
`default_nettype wire

[rtl/pel_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pel_result_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
interface pel_result_if;
  logic                                valid;
  logic                                ready;
  pel_pkg::status_t                    status;
  logic signed [pel_pkg::VALUE_W-1:0]  out_value;
  logic        [pel_pkg::OPOS_W-1:0]   out_position;
  logic        [pel_pkg::COUNT_W-1:0]  element_count;
  logic                                last;

  modport source (output valid, status, out_value, out_position, element_count, last,
                  input ready);
  modport sink   (input valid, status, out_value, out_position, element_count, last,
                  output ready);
endinterface
`default_nettype wire

[rtl/positional_list_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// A dump of a non-empty list yields one result transaction per element, each held until taken.
// One request at a time; the link walk reads the next-link RAM one slot per cycle.
// Reset (rst_n low, synchronous) empties the list at once; no clearing pass.
// ----------------------------------------------------------------------------
// positional_list_engine
// Doubly linked list of signed values in a slot pool, driven by a sequencer
// over value, next-link and prev-link RAMs and a free-slot stack.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = pel_pkg::CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pel_item_if.sink         in_item,
  pel_result_if.source     out_result
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > pel_pkg::IPOS_W) ? CW : pel_pkg::IPOS_W;

  pel_pkg::state_t  state_r, state_nxt;
  pel_pkg::func_t   op_r, op_nxt;
  pel_pkg::status_t o_status_r, o_status_nxt;

  logic [pel_pkg::VALUE_W-1:0] v_r, v_nxt;
  logic [pel_pkg::IPOS_W-1:0]  pos_r, pos_nxt;
  logic                        at_end_r, at_end_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [SW-1:0]               first_r, first_nxt;
  logic [SW-1:0]               last_r, last_nxt;
  logic [SW-1:0]               cur_r, cur_nxt;
  logic [CW-1:0]               k_r, k_nxt;
  logic                        pend_r, pend_nxt;
  logic [SW-1:0]               n_r, n_nxt;
  logic [SW-1:0]               p_r, p_nxt;
  logic [pel_pkg::VALUE_W-1:0] o_value_r, o_value_nxt;
  logic [pel_pkg::OPOS_W-1:0]  o_pos_r, o_pos_nxt;
  logic                        o_last_r, o_last_nxt;

  logic [SW-1:0]               rd_addr;
  logic                        val_we, nxt_we, prv_we;
  logic [SW-1:0]               val_wa, nxt_wa, prv_wa;
  logic [SW-1:0]               nxt_wd, prv_wd;
  logic [pel_pkg::VALUE_W-1:0] val_rdata;
  logic [SW-1:0]               nxt_rdata, prv_rdata;

  pel_pkg::free_ctl_t free_ctl;
  logic [SW-1:0]      alloc_slot;
  logic               none_free;

  logic [MW-1:0] in_pos_ext, cnt_ext, pos_ext;
  logic          full;
  logic [SW-1:0] cur_eff;
  logic          head, tail;

  assign in_pos_ext = MW'(in_item.item_position);
  assign cnt_ext    = MW'(count_r);
  assign pos_ext    = MW'(pos_r);
  assign full       = (cnt_ext >= MW'(CAPACITY)) || none_free;
  assign cur_eff    = pend_r ? nxt_rdata : cur_r;
  assign head       = (pos_r == '0);
  assign tail       = ((pos_ext + MW'(1)) == cnt_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pel_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    v_nxt        = v_r;
    pos_nxt      = pos_r;
    at_end_nxt   = at_end_r;
    count_nxt    = count_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    cur_nxt      = cur_r;
    k_nxt        = k_r;
    pend_nxt     = pend_r;
    n_nxt        = n_r;
    p_nxt        = p_r;
    o_status_nxt = o_status_r;
    o_value_nxt  = o_value_r;
    o_pos_nxt    = o_pos_r;
    o_last_nxt   = o_last_r;
    rd_addr      = cur_r;
    val_we       = 1'b0;
    val_wa       = n_r;
    nxt_we       = 1'b0;
    nxt_wa       = n_r;
    nxt_wd       = n_r;
    prv_we       = 1'b0;
    prv_wa       = n_r;
    prv_wd       = n_r;
    free_ctl     = '0;
    in_item.ready = 1'b0;

    unique case (state_r)
      pel_pkg::S_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid) begin
          op_nxt       = in_item.func;
          v_nxt        = in_item.item_value;
          pos_nxt      = in_item.item_position;
          cur_nxt      = first_r;
          k_nxt        = '0;
          pend_nxt     = 1'b0;
          o_status_nxt = pel_pkg::ST_OK;
          o_value_nxt  = '0;
          o_pos_nxt    = '0;
          o_last_nxt   = 1'b1;
          unique case (in_item.func)
            pel_pkg::FUNC_APPEND: begin
              at_end_nxt = 1'b1;
              if (full) begin
                o_status_nxt = pel_pkg::ST_FULL;
                state_nxt    = pel_pkg::S_RESP;
              end else begin
                state_nxt = pel_pkg::S_POP;
              end
            end
            pel_pkg::FUNC_INSERT: begin
              at_end_nxt = (in_pos_ext == cnt_ext);
              if (in_pos_ext > cnt_ext) begin
                o_status_nxt = pel_pkg::ST_BADPOS;
                state_nxt    = pel_pkg::S_RESP;
              end else if (full) begin
                o_status_nxt = pel_pkg::ST_FULL;
                state_nxt    = pel_pkg::S_RESP;
              end else begin
                state_nxt = pel_pkg::S_POP;
              end
            end
            pel_pkg::FUNC_REMOVE: begin
              if (count_r == '0) begin
                o_status_nxt = pel_pkg::ST_EMPTY;
                state_nxt    = pel_pkg::S_RESP;
              end else if (in_pos_ext >= cnt_ext) begin
                o_status_nxt = pel_pkg::ST_BADPOS;
                state_nxt    = pel_pkg::S_RESP;
              end else begin
                state_nxt = pel_pkg::S_WALK;
              end
            end
            pel_pkg::FUNC_DUMP: begin
              if (count_r == '0) begin
                o_status_nxt = pel_pkg::ST_EMPTY;
                state_nxt    = pel_pkg::S_RESP;
              end else begin
                state_nxt = pel_pkg::S_DRD;
              end
            end
            default: state_nxt = pel_pkg::S_IDLE;
          endcase
        end
      end

      pel_pkg::S_POP: begin
        free_ctl.pop = 1'b1;
        state_nxt    = pel_pkg::S_ALLOC;
      end

      pel_pkg::S_ALLOC: begin
        n_nxt     = alloc_slot;
        val_we    = 1'b1;
        val_wa    = alloc_slot;
        state_nxt = at_end_r ? pel_pkg::S_LINK1 : pel_pkg::S_WALK;
      end

      pel_pkg::S_LINK1: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (count_r == '0) begin
          first_nxt = n_r;
          last_nxt  = n_r;
          count_nxt = count_r + CW'(1);
          state_nxt = pel_pkg::S_RESP;
        end else begin
          prv_wd    = last_r;
          state_nxt = pel_pkg::S_LINK2;
        end
      end

      pel_pkg::S_LINK2: begin
        nxt_we    = 1'b1;
        nxt_wa    = last_r;
        last_nxt  = n_r;
        count_nxt = count_r + CW'(1);
        state_nxt = pel_pkg::S_RESP;
      end

      pel_pkg::S_WALK: begin
        cur_nxt = cur_eff;
        if (MW'(k_r) == pos_ext) begin
          state_nxt = pel_pkg::S_FOUND;
        end else begin
          rd_addr  = cur_eff;
          pend_nxt = 1'b1;
          k_nxt    = k_r + CW'(1);
        end
      end

      pel_pkg::S_FOUND: begin
        state_nxt = (op_r == pel_pkg::FUNC_REMOVE) ? pel_pkg::S_REM : pel_pkg::S_INS1;
      end

      pel_pkg::S_INS1: begin
        p_nxt     = prv_rdata;
        nxt_we    = 1'b1;
        nxt_wd    = cur_r;
        prv_we    = 1'b1;
        prv_wa    = cur_r;
        state_nxt = pel_pkg::S_INS2;
      end

      pel_pkg::S_INS2: begin
        prv_we = 1'b1;
        if (head) begin
          first_nxt = n_r;
        end else begin
          prv_wd = p_r;
          nxt_we = 1'b1;
          nxt_wa = p_r;
        end
        count_nxt = count_r + CW'(1);
        state_nxt = pel_pkg::S_RESP;
      end

      pel_pkg::S_REM: begin
        if (head && tail) begin
          first_nxt = '0;
          last_nxt  = '0;
        end else if (head) begin
          first_nxt = nxt_rdata;
          prv_we    = 1'b1;
          prv_wa    = nxt_rdata;
          prv_wd    = nxt_rdata;
        end else if (tail) begin
          last_nxt = prv_rdata;
          nxt_we   = 1'b1;
          nxt_wa   = prv_rdata;
          nxt_wd   = prv_rdata;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = prv_rdata;
          nxt_wd = nxt_rdata;
          prv_we = 1'b1;
          prv_wa = nxt_rdata;
          prv_wd = prv_rdata;
        end
        free_ctl.push = 1'b1;
        count_nxt     = count_r - CW'(1);
        state_nxt     = pel_pkg::S_RESP;
      end

      pel_pkg::S_DRD: begin
        state_nxt = pel_pkg::S_DLD;
      end

      pel_pkg::S_DLD: begin
        o_status_nxt = pel_pkg::ST_OK;
        o_value_nxt  = val_rdata;
        o_pos_nxt    = pel_pkg::OPOS_W'(k_r);
        o_last_nxt   = ((k_r + CW'(1)) == count_r);
        cur_nxt      = nxt_rdata;
        k_nxt        = k_r + CW'(1);
        state_nxt    = pel_pkg::S_DOUT;
      end

      pel_pkg::S_DOUT: begin
        if (out_result.ready) begin
          state_nxt = o_last_r ? pel_pkg::S_IDLE : pel_pkg::S_DRD;
        end
      end

      pel_pkg::S_RESP: begin
        if (out_result.ready) begin
          state_nxt = pel_pkg::S_IDLE;
        end
      end

      default: state_nxt = pel_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      first_r <= '0;
      last_r  <= '0;
    end else begin
      count_r <= count_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    v_r        <= v_nxt;
    pos_r      <= pos_nxt;
    at_end_r   <= at_end_nxt;
    cur_r      <= cur_nxt;
    k_r        <= k_nxt;
    pend_r     <= pend_nxt;
    n_r        <= n_nxt;
    p_r        <= p_nxt;
    o_status_r <= o_status_nxt;
    o_value_r  <= o_value_nxt;
    o_pos_r    <= o_pos_nxt;
    o_last_r   <= o_last_nxt;
  end

  pel_ram #(
    .WIDTH (pel_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_val (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_wa),
    .wdata (v_r),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  pel_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_next (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_wa),
    .wdata (nxt_wd),
    .raddr (rd_addr),
    .rdata (nxt_rdata)
  );

  pel_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_prev (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_wa),
    .wdata (prv_wd),
    .raddr (rd_addr),
    .rdata (prv_rdata)
  );

  pel_free #(
    .CAPACITY (CAPACITY)
  ) u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (free_ctl),
    .push_slot (cur_r),
    .slot      (alloc_slot),
    .none_free (none_free)
  );

  assign out_result.valid         = (state_r == pel_pkg::S_RESP) ||
                                    (state_r == pel_pkg::S_DOUT);
  assign out_result.status        = o_status_r;
  assign out_result.out_value     = o_value_r;
  assign out_result.out_position  = o_pos_r;
  assign out_result.element_count = pel_pkg::COUNT_W'(count_r);
  assign out_result.last          = o_last_r;

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_item.ready && out_result.valid))
    else $error("request accepted while a result is pending");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_result.valid && out_result.ready && out_result.last) |=> in_item.ready)
    else $error("engine not idle after final result transaction");

  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pel_pkg::S_POP) |-> !none_free)
    else $error("slot taken from an empty free stack");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");
`endif

endmodule
`default_nettype wire

[rtl/pel_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pel_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pel_ram #(
  parameter int WIDTH = pel_pkg::VALUE_W,
  parameter int DEPTH = pel_pkg::CAPACITY
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/pel_free.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pel_free
// Free-slot stack. Entries below the low-water mark were never written and
// read as their own index, so no init sweep is needed after reset.
// ----------------------------------------------------------------------------
module pel_free #(
  parameter int CAPACITY = pel_pkg::CAPACITY
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pel_pkg::free_ctl_t          ctl,
  input  wire logic [$clog2(CAPACITY)-1:0] push_slot,
  output logic      [$clog2(CAPACITY)-1:0] slot,
  output logic                             none_free
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] free_top_r, free_top_nxt;
  logic [CW-1:0] lwm_r, lwm_nxt;
  logic          fresh_r, fresh_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] top_idx;
  logic [SW-1:0] rdata;
  logic          we;

  assign top_idx = SW'(free_top_r - CW'(1));

  always_comb begin
    free_top_nxt = free_top_r;
    lwm_nxt      = lwm_r;
    fresh_nxt    = fresh_r;
    idx_nxt      = idx_r;
    we           = 1'b0;
    if (ctl.pop) begin
      idx_nxt      = top_idx;
      fresh_nxt    = (free_top_r <= lwm_r);
      free_top_nxt = free_top_r - CW'(1);
      if (free_top_r <= lwm_r) begin
        lwm_nxt = free_top_r - CW'(1);
      end
    end else if (ctl.push && (free_top_r < CW'(CAPACITY))) begin
      we           = 1'b1;
      free_top_nxt = free_top_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_top_r <= CW'(CAPACITY);
      lwm_r      <= CW'(CAPACITY);
    end else begin
      free_top_r <= free_top_nxt;
      lwm_r      <= lwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fresh_r <= fresh_nxt;
    idx_r   <= idx_nxt;
  end

  pel_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (SW'(free_top_r)),
    .wdata (push_slot),
    .raddr (top_idx),
    .rdata (rdata)
  );

  assign slot      = fresh_r ? idx_r : rdata;
  assign none_free = (free_top_r == '0);

endmodule
`default_nettype wire

[test/tb_positional_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A shadow list in a queue
// predicts every response; each response transaction is compared field by
// field with the oldest predicted one. Both channels idle at random, the
// result side holds off for a long stretch to back up the request side, and
// the stimulus covers the empty, full, bad-position and extreme-value cases.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
  import pel_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_REQUESTS = 110;

  typedef struct {
    status_t            status;
    logic signed [31:0] value;
    logic [3:0]         position;
    logic [4:0]         count;
    logic               last;
  } response_t;

  logic clk = 1'b0;
  logic rst_n;

  pel_item_if   item_bus ();
  pel_result_if result_bus ();

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (item_bus),
    .out_result(result_bus)
  );

  always #1 clk = ~clk;

  logic signed [31:0] shadow_list[$];
  response_t          due_responses[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 hold_off_cycles = 0;
  bit                 steady_flow = 1'b0;

  function automatic void queue_response(response_t r);
    due_responses = {due_responses, r};
  endfunction

  // Updates the shadow list and queues the responses one request causes.
  task automatic apply_to_shadow_list(func_t f, logic signed [31:0] v, logic [4:0] p);
    int        count;
    status_t   st;
    response_t r;
    count = shadow_list.size();
    st = ST_OK;
    case (f)
      FUNC_APPEND: begin
        if (count >= CAPACITY) st = ST_FULL;
        else shadow_list = {shadow_list, v};
      end
      FUNC_INSERT: begin
        if (p > count) st = ST_BADPOS;
        else if (count >= CAPACITY) st = ST_FULL;
        else shadow_list.insert(p, v);
      end
      FUNC_REMOVE: begin
        if (count == 0) st = ST_EMPTY;
        else if (p >= count) st = ST_BADPOS;
        else shadow_list.delete(p);
      end
      default: begin
        if (count == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < count; i++) begin
            r.status   = ST_OK;
            r.value    = shadow_list[i];
            r.position = i[3:0];
            r.count    = count[4:0];
            r.last     = (i == count - 1);
            queue_response(r);
          end
          return;
        end
      end
    endcase
    r.status   = st;
    r.value    = '0;
    r.position = '0;
    r.count    = 5'(shadow_list.size());
    r.last     = 1'b1;
    queue_response(r);
  endtask

  task automatic send_request(func_t f, logic signed [31:0] v, logic [4:0] p);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.func          <= f;
    item_bus.item_value    <= v;
    item_bus.item_position <= p;
    do @(posedge clk); while (!item_bus.ready);
    apply_to_shadow_list(f, v, p);
  endtask

  task automatic wait_for_responses();
    item_bus.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall per transaction, plus a long hold-off on request.
  initial begin
    int stall;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        result_bus.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = steady_flow ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid && hold_off_cycles == 0);
    end
  end

  always @(posedge clk) begin : check_responses
    response_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (due_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected response: status %0d value %0d pos %0d count %0d last %0b",
                   result_bus.status, result_bus.out_value, result_bus.out_position,
                   result_bus.element_count, result_bus.last);
      end else begin
        want = due_responses.pop_front();
        if (result_bus.status !== want.status || result_bus.out_value !== want.value ||
            result_bus.out_position !== want.position ||
            result_bus.element_count !== want.count || result_bus.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d value %0d pos %0d count %0d last %0b",
                     want.status, want.value, want.position, want.count, want.last);
            $display("          got      status %0d value %0d pos %0d count %0d last %0b",
                     result_bus.status, result_bus.out_value, result_bus.out_position,
                     result_bus.element_count, result_bus.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_empty_list_requests();
    send_request(FUNC_DUMP, 32'sd0, 5'd0);
    send_request(FUNC_REMOVE, 32'sd0, 5'd0);
    send_request(FUNC_REMOVE, -32'sd1, 5'd31);
    send_request(FUNC_INSERT, 32'sd5, 5'd1);
    send_request(FUNC_INSERT, 32'sd7, 5'd0);
    send_request(FUNC_REMOVE, 32'sd0, 5'd0);
  endtask

  task automatic test_edge_values_and_positions();
    send_request(FUNC_APPEND, 32'sh7fffffff, 5'd31);
    send_request(FUNC_APPEND, 32'sh80000000, 5'd0);
    send_request(FUNC_INSERT, 32'sd1, 5'd31);
    send_request(FUNC_INSERT, 32'sd2, 5'd3);
    send_request(FUNC_INSERT, -32'sd1, 5'd2);
    send_request(FUNC_INSERT, 32'sd0, 5'd0);
    send_request(FUNC_INSERT, 32'sh5a5a5a5a, 5'd2);
    send_request(FUNC_DUMP, 32'sh12345678, 5'd17);
    send_request(FUNC_REMOVE, 32'sd0, 5'd4);
    send_request(FUNC_REMOVE, 32'sd0, 5'd3);
    send_request(FUNC_REMOVE, 32'sd0, 5'd0);
    send_request(FUNC_REMOVE, 32'sd0, 5'd1);
    send_request(FUNC_DUMP, 32'sd0, 5'd0);
  endtask

  // Fill the list, then stall the result side behind a full dump.
  task automatic test_full_list_backpressure();
    while (shadow_list.size() < CAPACITY)
      send_request(FUNC_APPEND, $urandom, 5'($urandom_range(0, 31)));
    hold_off_cycles = 300;
    send_request(FUNC_DUMP, 32'sd0, 5'd0);
    send_request(FUNC_APPEND, 32'sd3, 5'd0);
    send_request(FUNC_INSERT, 32'sd4, 5'd16);
    send_request(FUNC_INSERT, 32'sd4, 5'd17);
    send_request(FUNC_REMOVE, 32'sd0, 5'd16);
    send_request(FUNC_REMOVE, 32'sd0, 5'd15);
    send_request(FUNC_INSERT, -32'sd9, 5'd7);
    send_request(FUNC_DUMP, 32'sd0, 5'd0);
    wait_for_responses();
  endtask

  task automatic test_random_traffic();
    int      count;
    int      roll;
    func_t   f;
    logic [4:0] p;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 20) steady_flow = 1'b1;
      if (n % 50 == 35) steady_flow = 1'b0;
      count = shadow_list.size();
      roll = $urandom_range(0, 99);
      if (roll < 30) f = FUNC_APPEND;
      else if (roll < 60) f = FUNC_INSERT;
      else if (roll < 85) f = FUNC_REMOVE;
      else f = FUNC_DUMP;
      p = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 9) < 8) begin
        if (f == FUNC_INSERT) p = 5'($urandom_range(0, count));
        else if (f == FUNC_REMOVE && count > 0) p = 5'($urandom_range(0, count - 1));
      end
      send_request(f, $urandom, p);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n                  <= 1'b0;
    item_bus.valid         <= 1'b0;
    item_bus.func          <= FUNC_APPEND;
    item_bus.item_value    <= '0;
    item_bus.item_position <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list_requests();
    test_edge_values_and_positions();
    test_full_list_backpressure();
    test_random_traffic();

    wait_for_responses();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && due_responses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
